// ===== rtl/core/dq_pkg.sv =====
// Package for the double-ended queue: operation and status codes, field widths
// and parameter defaults. It depends on nothing else.
`timescale 1ns / 1ps

package dq_pkg;

    // Field widths fixed by the item format
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] OP_PEEK_FRONT = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

endpackage

// ===== rtl/core/dq_store.sv =====
// Element store of the double-ended queue: one write port and one read port,
// read data registered. Uses dq_pkg for defaults.
`timescale 1ns / 1ps

module dq_store #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);
    import dq_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Write the pushed element
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dq_ctrl.sv =====
// Control of the double-ended queue: head, tail and count registers, operation
// decode, store addressing and the registered result. Uses dq_pkg.
`timescale 1ns / 1ps

module dq_ctrl #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
    parameter int AW         = $clog2(DEPTH),
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [dq_pkg::FUNC_W-1:0]     i_func,
    input  logic [DATA_WIDTH-1:0]         i_push_value,
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output logic [DATA_WIDTH-1:0]         o_wdata,
    output logic [AW-1:0]                 o_raddr,
    output logic                          o_strobe,
    output logic                          o_take,
    output logic [dq_pkg::STATUS_W-1:0]   o_status,
    output logic [CW-1:0]                 o_occupancy
);
    import dq_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [AW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_count, n_count;
    logic                r_strobe;
    logic                r_take, n_take;
    logic [STATUS_W-1:0] r_status, n_status;

    logic [AW-1:0] head_next, head_prev, tail_next, tail_prev;
    logic          full, empty;

    // Ring neighbors of the pointers
    assign head_next = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign head_prev = (r_head == '0) ? LAST : r_head - 1'b1;
    assign tail_next = (r_tail == LAST) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? LAST : r_tail - 1'b1;
    assign full      = (r_count == FULL);
    assign empty     = (r_count == '0);

    // Decode the operation; on an error or an unused code nothing moves
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_take   = 1'b0;
        n_status = ST_OK;
        o_we     = 1'b0;
        o_waddr  = r_tail;
        o_raddr  = r_head;
        case (i_func)
            OP_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    o_we    = i_accept;
                    o_waddr = r_tail;
                    n_tail  = tail_next;
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    o_we    = i_accept;
                    o_waddr = head_prev;
                    n_head  = head_prev;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_BACK: begin
                o_raddr = tail_prev;
                if (empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_tail  = tail_prev;
                    n_count = r_count - 1'b1;
                    n_take  = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_head  = head_next;
                    n_count = r_count - 1'b1;
                    n_take  = 1'b1;
                end
            end
            OP_PEEK_FRONT: begin
                if (empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_take = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign o_wdata = i_push_value;

    // Advance the queue state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_accept;
            if (i_accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    // Hold the result fields that go out with the store read
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_take   <= n_take;
            r_status <= n_status;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_take      = r_take;
    assign o_status    = r_status;
    assign o_occupancy = r_count;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Top level of the bounded double-ended queue: ties the control to the element
// store. Uses dq_pkg, dq_ctrl and dq_store.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------
//  request | start high, busy low  | i_func, i_push_value
//  result  | o_strobe, one cycle   | o_read_value, o_status, o_occupancy
//
// One transfer per cycle; each result appears on the cycle after its request,
// set by the registered read of the element store.
// Pointers and count update at the request edge, so a following operation
// always sees the store and state left by the previous one.
// busy stays low: the store takes a write and a read every cycle.
// Synchronous reset empties the queue; store contents are not cleared.
`timescale 1ns / 1ps

module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
    parameter int AW         = $clog2(DEPTH),
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [dq_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [DATA_WIDTH-1:0]       i_push_value,
    output logic                               o_strobe,
    output logic signed [DATA_WIDTH-1:0]       o_read_value,
    output logic [dq_pkg::STATUS_W-1:0]        o_status,
    output logic [CW-1:0]                      o_occupancy
);
    import dq_pkg::*;

    logic                  accept;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [AW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] rdata;
    logic                  take;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    dq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_func       (i_func),
        .i_push_value (i_push_value),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr      (raddr),
        .o_strobe     (o_strobe),
        .o_take       (take),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    dq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Drop the read data unless a pop or peek succeeded
    assign o_read_value = take ? rdata : '0;

    // Every result answers the request of the cycle before
    property p_strobe_follows;
        @(posedge i_clk) disable iff (!i_rst_n)
            $past(i_rst_n) |-> (o_strobe == $past(accept));
    endproperty
    a_strobe_follows: assert property (p_strobe_follows)
        else $error("result strobe does not match request transfer");

    // Underflow only on an empty queue
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_UNDERFLOW) |-> (o_occupancy == '0))
        else $error("underflow reported on a non-empty queue");

    // Overflow only on a full queue
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_OVERFLOW) |-> (o_occupancy == CW'(DEPTH)))
        else $error("overflow reported on a queue that is not full");

    // Errors never return data
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_read_value == '0))
        else $error("error result carries a value");

    // Count never exceeds the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_occupancy <= CW'(DEPTH))
        else $error("occupancy beyond depth");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for double_ended_queue: directed corner cases, fill and
// drain rounds, and biased random traffic, all checked against a local deque mirror.
// Depends on dq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module testbench;

    import dq_pkg::*;

    localparam int DEPTH  = DEPTH_DEF;
    localparam int DW     = DATA_WIDTH_DEF;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int FUNC_MAX = (1 << FUNC_W) - 1;

    localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic signed [DW-1:0] read_value;
        logic [STATUS_W-1:0]  status;
        logic [CW-1:0]        occupancy;
    } t_deque_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func = '0;
    logic signed [DW-1:0] i_push_value = '0;
    logic                 o_strobe;
    logic signed [DW-1:0] o_read_value;
    logic [STATUS_W-1:0]  o_status;
    logic [CW-1:0]        o_occupancy;

    // Mirror of the queue contents and pointers
    logic signed [DW-1:0] mirror_store [DEPTH];
    int unsigned          mirror_head;
    int unsigned          mirror_tail;
    int unsigned          mirror_count;

    t_deque_result pending_results [$];

    int unsigned idle_pct;
    int unsigned ops_sent;
    int unsigned results_seen;
    int unsigned overflow_hits;
    int unsigned underflow_hits;
    int unsigned error_count;

    double_ended_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_push_value(i_push_value),
        .o_strobe    (o_strobe),
        .o_read_value(o_read_value),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one operation to the mirror and return the result it must produce
    function automatic t_deque_result deque_apply(input logic [FUNC_W-1:0] op,
                                                  input logic signed [DW-1:0] value);
        t_deque_result res;
        res.read_value = '0;
        res.status     = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (mirror_count >= DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else if (op == OP_PUSH_BACK) begin
                    mirror_store[mirror_tail] = value;
                    mirror_tail = (mirror_tail == DEPTH - 1) ? 0 : mirror_tail + 1;
                    mirror_count++;
                end else begin
                    mirror_head = (mirror_head == 0) ? DEPTH - 1 : mirror_head - 1;
                    mirror_store[mirror_head] = value;
                    mirror_count++;
                end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (mirror_count == 0) begin
                    res.status = ST_UNDERFLOW;
                end else if (op == OP_POP_BACK) begin
                    mirror_tail = (mirror_tail == 0) ? DEPTH - 1 : mirror_tail - 1;
                    res.read_value = mirror_store[mirror_tail];
                    mirror_count--;
                end else if (op == OP_POP_FRONT) begin
                    res.read_value = mirror_store[mirror_head];
                    mirror_head = (mirror_head == DEPTH - 1) ? 0 : mirror_head + 1;
                    mirror_count--;
                end else begin
                    res.read_value = mirror_store[mirror_head];
                end
            end
            default: ;
        endcase
        res.occupancy = CW'(mirror_count);
        return res;
    endfunction

    // Drive one operation, hold it until the transfer, then log its expected result
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic signed [DW-1:0] value);
        t_deque_result res;
        start        <= 1'b1;
        i_func       <= op;
        i_push_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        res = deque_apply(op, value);
        if (res.status == ST_OVERFLOW) overflow_hits++;
        if (res.status == ST_UNDERFLOW) underflow_hits++;
        pending_results.push_back(res);
        ops_sent++;
        // Idle each cycle with the phase's probability
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold the request side until every outstanding result is back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(19))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_unused_op();
        return FUNC_W'($urandom_range(int'(OP_PEEK_FRONT) + 1, FUNC_MAX));
    endfunction

    function automatic logic [FUNC_W-1:0] pick_push_op();
        return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_read_op();
        case ($urandom_range(2))
            0:       return OP_POP_BACK;
            1:       return OP_POP_FRONT;
            default: return OP_PEEK_FRONT;
        endcase
    endfunction

    // Empty-queue errors, unused selectors, extreme values, every operation at least once
    task automatic test_directed();
        send_op(OP_POP_BACK, VAL_MAX);
        send_op(OP_POP_FRONT, VAL_MIN);
        send_op(OP_PEEK_FRONT, '1);
        send_op(FUNC_W'(FUNC_MAX), '0);
        send_op(pick_unused_op(), $urandom);
        send_op(OP_PUSH_BACK, VAL_MAX);
        send_op(OP_PUSH_FRONT, VAL_MIN);
        send_op(OP_PUSH_BACK, '1);
        send_op(OP_PUSH_FRONT, '0);
        send_op(OP_PEEK_FRONT, $urandom);
        send_op(FUNC_W'(int'(OP_PEEK_FRONT) + 1), $urandom);
        send_op(OP_POP_FRONT, $urandom);
        send_op(OP_POP_BACK, $urandom);
        send_op(OP_POP_FRONT, $urandom);
        send_op(OP_POP_BACK, $urandom);
        send_op(OP_PEEK_FRONT, $urandom);
        wait_drained();
    endtask

    // Fill to capacity, hit overflow, then drain and hit underflow; pointers wrap
    task automatic test_fill_drain(input int unsigned rounds);
        repeat (rounds) begin
            while (mirror_count < DEPTH) send_op(pick_push_op(), pick_value());
            send_op(OP_PUSH_BACK, pick_value());
            send_op(OP_PUSH_FRONT, pick_value());
            send_op(OP_PEEK_FRONT, $urandom);
            send_op(pick_unused_op(), $urandom);
            while (mirror_count > 0) send_op(pick_read_op(), $urandom);
            send_op(OP_POP_BACK, $urandom);
            send_op(OP_POP_FRONT, $urandom);
            send_op(OP_PEEK_FRONT, $urandom);
        end
    endtask

    // Random traffic drifting between fill and drain so both ends are reached
    task automatic test_random(input int unsigned n_ops, input int unsigned pct);
        bit filling;
        int unsigned push_pct;
        filling  = 1'b1;
        idle_pct = pct;
        repeat (n_ops) begin
            if ($urandom_range(19) == 0) filling = !filling;
            push_pct = filling ? 75 : 25;
            if ($urandom_range(99) < 3)
                send_op(pick_unused_op(), $urandom);
            else if ($urandom_range(99) < push_pct)
                send_op(pick_push_op(), pick_value());
            else
                send_op(pick_read_op(), $urandom);
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_deque_result want;
        if (i_rst_n && o_strobe === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no pending operation: value %0d status %0d occ %0d",
                       o_read_value, o_status, o_occupancy);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, o_read_value);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, o_occupancy);
                    error_count++;
                end
            end
        end
    end

    initial begin
        mirror_head    = 0;
        mirror_tail    = 0;
        mirror_count   = 0;
        idle_pct       = 0;
        ops_sent       = 0;
        results_seen   = 0;
        overflow_hits  = 0;
        underflow_hits = 0;
        error_count    = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_drain(2);
        test_random(140, 0);
        wait_drained();
        test_random(140, 52);
        test_fill_drain(1);
        // receiver stalls are impossible here; run this phase back to back
        test_random(140, 0);
        wait_drained();
        test_random(140, 21);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Ran %0d deque operations (push/pop at both ends, peek, unused selectors),",
                 ops_sent);
        $display("checked %0d results, %0d overflows and %0d underflows among them.",
                 results_seen, overflow_hits, underflow_hits);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
